>>> hw/rtl/crcd_pkg.sv
// shared types, constants and the crc-16 byte update for the packet deframer
package crcd_pkg;

  localparam int unsigned PAYLOAD_DEPTH = 256;

  localparam logic [7:0]  START_BYTE_RST = 8'hA1;
  localparam logic [7:0]  MAX_LENGTH_RST = 8'd200;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] packet_type;
    logic [7:0] packet_length;
    logic [7:0] read_data;
  } out_item_t;

  // result of one item as seen by the output pipeline
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] packet_type;
    logic [7:0] packet_length;
    logic       rd_ok;
  } frm_res_t;

  // reflected crc-16, poly 0x8408, one byte
  function automatic logic [15:0] crc_byte(logic [7:0] data, logic [15:0] crc);
    logic [7:0]  b;
    logic [15:0] r;
    b = data ^ crc[7:0];
    b = b ^ {b[3:0], 4'b0000};
    r = {b, crc[15:8]} ^ {12'b0, b[7:4]} ^ {5'b0, b, 3'b000};
    return r;
  endfunction

endpackage

>>> hw/rtl/crcd_if.sv
// valid/ready channel interfaces for input items and result items
interface crcd_in_if;
  logic               valid;
  logic               ready;
  crcd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crcd_out_if;
  logic                valid;
  logic                ready;
  crcd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/crcd_ram.sv
// generic single write port ram with registered read
module crcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/crcd_framer.sv
// frame state machine, running crc and payload store control
module crcd_framer #(
  parameter int unsigned PAYLOAD_DEPTH = crcd_pkg::PAYLOAD_DEPTH,
  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  crcd_pkg::in_item_t item_i,
  input  logic [7:0]         start_byte_i,
  input  logic [7:0]         max_length_i,
  output crcd_pkg::frm_res_t res_o,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [7:0]         ram_wdata_o,
  output logic               ram_re_o,
  output logic [AW-1:0]      ram_raddr_o
);

  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_START   = 3'd1;
  localparam logic [2:0] ST_TYPE    = 3'd2;
  localparam logic [2:0] ST_LENGTH  = 3'd3;
  localparam logic [2:0] ST_CRCLO   = 3'd4;
  localparam logic [2:0] ST_PAYLOAD = 3'd5;

  localparam logic [8:0] DEPTH_W = 9'(PAYLOAD_DEPTH);

  logic [2:0]  state_q, state_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  length_q, length_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  count_q, count_d;

  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [15:0] rx_crc_full;
  logic [7:0]  count_inc;
  logic        count_in_store;

  assign b              = item_i.rx_byte;
  assign crc_upd        = crcd_pkg::crc_byte(b, crc_q);
  assign rx_crc_full    = {b, rx_crc_q[7:0]};
  assign count_inc      = count_q + 8'd1;
  assign count_in_store = {1'b0, count_q} < DEPTH_W;

  always_comb begin
    state_d  = state_q;
    type_d   = type_q;
    length_d = length_q;
    rx_crc_d = rx_crc_q;
    crc_d    = crc_q;
    count_d  = count_q;
    res_o    = '0;
    ram_we_o = 1'b0;
    ram_re_o = 1'b0;
    if (accept_i) begin
      if (item_i.req_type == crcd_pkg::REQ_READ) begin
        res_o.valid = 1'b1;
        res_o.kind  = crcd_pkg::KIND_READ;
        res_o.rd_ok = (item_i.read_index < length_q) &&
                      ({1'b0, item_i.read_index} < DEPTH_W);
        ram_re_o    = 1'b1;
      end else begin
        case (state_q)
          ST_START: begin
            type_d  = b;
            crc_d   = crc_upd;
            state_d = ST_TYPE;
          end
          ST_TYPE: begin
            if (b <= max_length_i) begin
              length_d = b;
              crc_d    = crc_upd;
              state_d  = ST_LENGTH;
            end else begin
              state_d = ST_HUNT;
            end
          end
          ST_LENGTH: begin
            rx_crc_d = {8'h00, b};
            state_d  = ST_CRCLO;
          end
          ST_CRCLO: begin
            rx_crc_d = rx_crc_full;
            if (length_q == 8'd0) begin
              res_o.valid         = (crc_q == rx_crc_full);
              res_o.kind          = crcd_pkg::KIND_PACKET;
              res_o.packet_type   = type_q;
              res_o.packet_length = length_q;
              state_d             = ST_HUNT;
              count_d             = 8'd0;
            end else begin
              state_d = ST_PAYLOAD;
            end
          end
          ST_PAYLOAD: begin
            ram_we_o = count_in_store;
            crc_d    = crc_upd;
            count_d  = count_inc;
            if (count_inc == length_q) begin
              res_o.valid         = (crc_upd == rx_crc_q);
              res_o.kind          = crcd_pkg::KIND_PACKET;
              res_o.packet_type   = type_q;
              res_o.packet_length = length_q;
              state_d             = ST_HUNT;
              count_d             = 8'd0;
            end
          end
          default: begin
            state_d = ST_HUNT;
            if (b == start_byte_i) begin
              crc_d   = crcd_pkg::CRC_INIT;
              count_d = 8'd0;
              state_d = ST_START;
            end
          end
        endcase
      end
    end
  end

  assign ram_waddr_o = count_q[AW-1:0];
  assign ram_wdata_o = b;
  assign ram_raddr_o = item_i.read_index[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HUNT;
      type_q   <= 8'h00;
      length_q <= 8'h00;
      rx_crc_q <= 16'h0000;
      crc_q    <= crcd_pkg::CRC_INIT;
      count_q  <= 8'h00;
    end else begin
      state_q  <= state_d;
      type_q   <= type_d;
      length_q <= length_d;
      rx_crc_q <= rx_crc_d;
      crc_q    <= crc_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hw/rtl/crc16_packet_deframer_top.sv
// top level of the crc-16 framed packet deframer
// in_i carries one request per transfer: req_type 0 feeds a received byte
// into the frame parser, req_type 1 reads a stored payload byte.
// out_o carries one result per transfer: kind 0 reports a packet whose
// crc matched (type and length), kind 1 returns read data (0 past length).
// a received byte that does not complete a good packet gives no result.
// start_byte and max_length are written over the apb port (0x0 and 0x4);
// the user must write them only while the block is idle; the block does not enforce this.
// a result goes from the input transfer through the frame logic into the
// s1 stage, which takes the payload ram read data, and then into the output
// register. one request is taken every cycle while in_i.ready is high.
// when out_o is stalled the two result stages fill up and in_i.ready drops
// only once both hold a result.
// reset returns the parser to hunting for the start byte, the crc to
// 0xffff, the registers to 0xa1 and 200 and empties both result stages.
// the payload ram is not cleared.
module crc16_packet_deframer_top #(
  parameter int unsigned PAYLOAD_DEPTH = crcd_pkg::PAYLOAD_DEPTH,
  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  crcd_in_if.sink                       in_i,
  crcd_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crcd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [7:0] start_byte_q;
  logic [7:0] max_length_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= crcd_pkg::START_BYTE_RST;
      max_length_q <= crcd_pkg::MAX_LENGTH_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == crcd_pkg::REG_START_BYTE) begin
        start_byte_q <= pwdata[7:0];
      end else begin
        max_length_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == crcd_pkg::REG_MAX_LENGTH) ? {24'h0, max_length_q}
                                                         : {24'h0, start_byte_q};

  logic               in_acc;
  crcd_pkg::frm_res_t res;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;

  crcd_framer #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .item_i       (in_i.data),
    .start_byte_i (start_byte_q),
    .max_length_i (max_length_q),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  crcd_ram #(
    .WIDTH(8),
    .DEPTH(PAYLOAD_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result pipeline: s1 waits for ram read data, out register feeds out_o
  crcd_pkg::frm_res_t  s1_q;
  logic                out_valid_q;
  crcd_pkg::out_item_t out_q, out_d;
  logic                out_free;
  logic                s1_adv;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_q.valid && out_free;
  assign in_i.ready = !s1_q.valid || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    out_d.kind          = s1_q.kind;
    out_d.packet_type   = s1_q.packet_type;
    out_d.packet_length = s1_q.packet_length;
    out_d.read_data     = s1_q.rd_ok ? ram_rdata : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_q <= res;
      end else if (s1_adv) begin
        s1_q.valid <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_q.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.data.req_type == crcd_pkg::REQ_READ
    |=> s1_q.valid && s1_q.kind == crcd_pkg::KIND_READ)
    else $error("read transfer did not reach the result stage");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_q.valid && out_valid_q && !out_o.ready)
    else $error("input stalled with a free result stage");

  a_packet_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == crcd_pkg::KIND_PACKET |-> out_q.read_data == 8'h00)
    else $error("packet result carries read data");

  a_read_no_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == crcd_pkg::KIND_READ
    |-> out_q.packet_type == 8'h00 && out_q.packet_length == 8'h00)
    else $error("read result carries packet header");

  a_s1_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("s1 result lost on its way to the output register");

endmodule

>>> sim/tb_crc16_packet_deframer_top.sv
// testbench for the crc-16 packet deframer: directed frame table, then random framed traffic
`timescale 1ns / 1ps

module tb_crc16_packet_deframer_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam crcd_pkg::out_item_t READ_ZERO =
    crcd_pkg::out_item_t'{crcd_pkg::KIND_READ, 8'h00, 8'h00, 8'h00};
  localparam crcd_pkg::out_item_t NO_RESULT =
    crcd_pkg::out_item_t'{crcd_pkg::KIND_PACKET, 8'h00, 8'h00, 8'h00};

  typedef enum logic [2:0] {
    HUNT, GOT_START, GOT_TYPE, GOT_LENGTH, GOT_CRC_LO, IN_PAYLOAD
  } frame_phase_e;

  typedef struct {
    crcd_pkg::in_item_t  item;
    bit                  typed;
    crcd_pkg::out_item_t result;
  } stim_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [crcd_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  crcd_in_if  in_if ();
  crcd_out_if out_if ();

  crc16_packet_deframer_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]   cfg_start = crcd_pkg::START_BYTE_RST;
  logic [7:0]   cfg_max_len = crcd_pkg::MAX_LENGTH_RST;
  frame_phase_e phase = HUNT;
  logic [7:0]   hold_type = 8'h00;
  logic [7:0]   hold_len = 8'h00;
  logic [7:0]   pay_count = 8'h00;
  logic [15:0]  crc_rx = 16'h0000;
  logic [15:0]  crc_run = crcd_pkg::CRC_INIT;
  logic [7:0]   pay_mem [crcd_pkg::PAYLOAD_DEPTH];
  bit           pay_written [crcd_pkg::PAYLOAD_DEPTH];

  crcd_pkg::out_item_t results_due [$];
  stim_row_t           directed_rows [$];
  logic [7:0]          body_buf [$];
  logic [7:0]          frame_buf [$];

  int unsigned  fail_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  packets_seen = 0;
  int unsigned  cycle_count = 0;
  bit           quiet = 1'b0;

  function automatic logic [15:0] crc16_update(input logic [7:0] data,
                                               input logic [15:0] crc);
    logic [15:0] c;
    int unsigned i;
    c = crc ^ {8'h00, data};
    for (i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // advances the frame state by one request, returns 1 when a result is due
  function automatic bit deframe_step(input crcd_pkg::in_item_t it,
                                      output crcd_pkg::out_item_t res);
    logic [7:0]  b;
    int unsigned idx;
    bit          done;
    b = it.rx_byte;
    res = NO_RESULT;
    done = 1'b0;
    if (it.req_type == crcd_pkg::REQ_READ) begin
      idx = {24'h000000, it.read_index};
      res = READ_ZERO;
      if (idx < hold_len && idx < crcd_pkg::PAYLOAD_DEPTH) res.read_data = pay_mem[idx];
      return 1'b1;
    end
    case (phase)
      GOT_START: begin
        hold_type = b;
        crc_run = crc16_update(b, crc_run);
        phase = GOT_TYPE;
      end
      GOT_TYPE: begin
        if (b <= cfg_max_len) begin
          hold_len = b;
          crc_run = crc16_update(b, crc_run);
          phase = GOT_LENGTH;
        end else begin
          phase = HUNT;
        end
      end
      GOT_LENGTH: begin
        crc_rx = {8'h00, b};
        phase = GOT_CRC_LO;
      end
      GOT_CRC_LO: begin
        crc_rx[15:8] = b;
        if (hold_len == 8'h00) done = 1'b1;
        else phase = IN_PAYLOAD;
      end
      IN_PAYLOAD: begin
        pay_mem[pay_count] = b;
        pay_written[pay_count] = 1'b1;
        crc_run = crc16_update(b, crc_run);
        pay_count = pay_count + 8'd1;
        if (pay_count == hold_len) done = 1'b1;
      end
      default: begin
        phase = HUNT;
        if (b == cfg_start) begin
          crc_run = crcd_pkg::CRC_INIT;
          pay_count = 8'h00;
          phase = GOT_START;
        end
      end
    endcase
    if (done) begin
      phase = HUNT;
      pay_count = 8'h00;
      if (crc_run == crc_rx) begin
        res.kind = crcd_pkg::KIND_PACKET;
        res.packet_type = hold_type;
        res.packet_length = hold_len;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // frame bytes for the current start byte, payload taken from body_buf
  function automatic void build_frame(input logic [7:0] ptype, input logic [7:0] plen,
                                      input bit corrupt);
    logic [15:0] crc;
    crc = crc16_update(plen, crc16_update(ptype, crcd_pkg::CRC_INIT));
    foreach (body_buf[k]) crc = crc16_update(body_buf[k], crc);
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    frame_buf.delete();
    frame_buf.push_back(cfg_start);
    frame_buf.push_back(ptype);
    frame_buf.push_back(plen);
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
    foreach (body_buf[k]) frame_buf.push_back(body_buf[k]);
  endfunction

  function automatic void add_row(input logic rt, input logic [7:0] rx, input logic [7:0] idx,
                                  input bit typed, input crcd_pkg::out_item_t res);
    stim_row_t row;
    row.item.req_type = rt;
    row.item.rx_byte = rx;
    row.item.read_index = idx;
    row.typed = typed;
    row.result = res;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_frame_rows(input logic [7:0] ptype, input logic [7:0] plen,
                                         input bit corrupt);
    build_frame(ptype, plen, corrupt);
    foreach (frame_buf[k]) begin
      if (k == frame_buf.size() - 1 && !corrupt) begin
        add_row(crcd_pkg::REQ_BYTE, frame_buf[k], 8'h00, 1'b1,
                crcd_pkg::out_item_t'{crcd_pkg::KIND_PACKET, ptype, plen, 8'h00});
      end else begin
        add_row(crcd_pkg::REQ_BYTE, frame_buf[k], 8'h00, 1'b0, NO_RESULT);
      end
    end
  endfunction

  task automatic send_item(input crcd_pkg::in_item_t it, input bit typed,
                           input crcd_pkg::out_item_t typed_res);
    crcd_pkg::out_item_t res;
    bit                  has_res;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    has_res = deframe_step(it, res);
    if (typed) results_due.push_back(typed_res);
    else if (has_res) results_due.push_back(res);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    crcd_pkg::in_item_t it;
    it.req_type = crcd_pkg::REQ_BYTE;
    it.rx_byte = b;
    it.read_index = 8'($urandom_range(0, 255));
    send_item(it, 1'b0, NO_RESULT);
  endtask

  // never points at a payload entry that was not written yet
  task automatic send_read();
    crcd_pkg::in_item_t it;
    it.req_type = crcd_pkg::REQ_READ;
    it.rx_byte = 8'($urandom_range(0, 255));
    it.read_index = 8'($urandom_range(0, 255));
    if (hold_len != 8'h00 && $urandom_range(0, 1) == 0) begin
      it.read_index = 8'($urandom_range(0, hold_len - 1));
    end
    if (it.read_index < hold_len && !pay_written[it.read_index]) begin
      it.read_index = 8'($urandom_range(hold_len, 255));
    end
    send_item(it, 1'b0, NO_RESULT);
  endtask

  task automatic send_frame(input logic [7:0] ptype, input logic [7:0] plen, input bit corrupt);
    int unsigned i;
    body_buf.delete();
    for (i = 0; i < plen; i++) body_buf.push_back(8'($urandom_range(0, 255)));
    build_frame(ptype, plen, corrupt);
    foreach (frame_buf[k]) begin
      if ($urandom_range(0, 9) == 0) send_read();
      send_byte(frame_buf[k]);
    end
  endtask

  task automatic run_traffic(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  lim;
    logic [7:0]  plen;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      lim = (cfg_max_len < 8'd6) ? cfg_max_len : 8'd6;
      if (pick < 62) begin
        plen = 8'($urandom_range(0, lim));
        if ($urandom_range(0, 9) == 0) begin
          plen = 8'($urandom_range(0, (cfg_max_len < 8'd40) ? cfg_max_len : 8'd40));
        end
        send_frame(8'($urandom_range(0, 255)), plen, $urandom_range(0, 7) == 0);
      end else if (pick < 82) begin
        send_read();
      end else if (pick < 90 && cfg_max_len != 8'hFF) begin
        send_byte(cfg_start);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(cfg_max_len + 1, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(input logic reg_sel, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {24'h000000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== value) begin
      $error("register %0d: expected %0h, got %0h", reg_sel, value, prdata[7:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (reg_sel == crcd_pkg::REG_START_BYTE) cfg_start = value;
    else cfg_max_len = value;
  endtask

  task automatic check_result(input crcd_pkg::out_item_t got);
    crcd_pkg::out_item_t want;
    if (results_due.size() == 0) begin
      $error("result with nothing expected: kind %0d type %0h length %0h data %0h",
             got.kind, got.packet_type, got.packet_length, got.read_data);
      fail_count++;
      return;
    end
    want = results_due.pop_front();
    results_seen++;
    if (want.kind == crcd_pkg::KIND_PACKET) packets_seen++;
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      fail_count++;
    end
    if (got.packet_type !== want.packet_type) begin
      $error("packet_type: expected %0h, got %0h", want.packet_type, got.packet_type);
      fail_count++;
    end
    if (got.packet_length !== want.packet_length) begin
      $error("packet_length: expected %0h, got %0h", want.packet_length, got.packet_length);
      fail_count++;
    end
    if (got.read_data !== want.read_data) begin
      $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
      fail_count++;
    end
  endtask

  // result side: transfer check and random back-pressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) check_result(out_if.data);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               results_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;

    add_row(crcd_pkg::REQ_READ, 8'h00, 8'h00, 1'b1, READ_ZERO);
    add_row(crcd_pkg::REQ_READ, 8'hFF, 8'hFF, 1'b1, READ_ZERO);
    add_row(crcd_pkg::REQ_BYTE, 8'h00, 8'hFF, 1'b0, NO_RESULT);
    body_buf.delete();
    add_frame_rows(8'hFF, 8'h00, 1'b0);
    add_frame_rows(8'h5A, 8'h00, 1'b1);
    body_buf.delete();
    body_buf.push_back(8'h00);
    body_buf.push_back(8'hFF);
    add_frame_rows(8'h00, 8'h02, 1'b0);
    add_row(crcd_pkg::REQ_READ, 8'h00, 8'h01, 1'b0, NO_RESULT);
    add_row(crcd_pkg::REQ_READ, 8'h00, 8'h02, 1'b1, READ_ZERO);
    // oversize length aborts, stored length stays at two
    add_row(crcd_pkg::REQ_BYTE, crcd_pkg::START_BYTE_RST, 8'h00, 1'b0, NO_RESULT);
    add_row(crcd_pkg::REQ_BYTE, 8'h33, 8'h00, 1'b0, NO_RESULT);
    add_row(crcd_pkg::REQ_BYTE, crcd_pkg::MAX_LENGTH_RST + 8'd1, 8'h00, 1'b0, NO_RESULT);
    add_row(crcd_pkg::REQ_READ, 8'h00, 8'h00, 1'b0, NO_RESULT);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].result);
    end
    run_traffic(40);

    wait_drain();
    set_register(crcd_pkg::REG_START_BYTE, 8'h00);
    set_register(crcd_pkg::REG_MAX_LENGTH, 8'hFF);
    send_frame(8'($urandom_range(0, 255)), 8'hFF, 1'b0);
    run_traffic(25);

    wait_drain();
    set_register(crcd_pkg::REG_START_BYTE, 8'hFF);
    set_register(crcd_pkg::REG_MAX_LENGTH, 8'h00);
    send_frame(8'($urandom_range(0, 255)), 8'h00, 1'b0);
    run_traffic(25);

    wait_drain();
    set_register(crcd_pkg::REG_START_BYTE, 8'($urandom_range(0, 255)));
    set_register(crcd_pkg::REG_MAX_LENGTH, 8'd12);
    send_frame(8'($urandom_range(0, 255)), 8'd12, 1'b0);
    run_traffic(20);
    quiet = 1'b1;
    run_traffic(20);

    wait_drain();
    $display("%0d requests sent over four register settings", items_sent);
    $display("%0d results checked, %0d of them accepted packets", results_seen, packets_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
